### sv/bba_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the buddy block allocator
// no dependencies

package bba_pkg;

   // default geometry of the managed pool
   localparam int DEF_BLOCK_BYTES = 64;
   localparam int DEF_BLOCK_COUNT = 256;

   // payload widths
   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 15;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 9;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_USAGE = 2'd2
   } kind_type;

   // response codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_INVALID_SIZE = 2'd1,
      ST_NO_MEMORY    = 2'd2,
      ST_INVALID_PTR  = 2'd3
   } status_type;

   // request classification handed from the decoder to the sequencer
   typedef struct packed {
      logic       done;
      status_type status;
      logic       alloc;
   } decode_type;

endpackage

### sv/bba_channels.sv
`timescale 1ns / 1ps
// valid/ready channels of the buddy block allocator
// depends on bba_pkg

interface bba_req_if import bba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SIZE_W-1:0] request_bytes;
   logic [ADDR_W-1:0] release_address;

   modport source (output valid, kind, request_bytes, release_address, input ready);
   modport sink   (input valid, kind, request_bytes, release_address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   granted_address;
   logic [USED_W-1:0]   used_blocks;

   modport source (output valid, status, granted_address, used_blocks, input ready);
   modport sink   (input valid, status, granted_address, used_blocks, output ready);
endinterface

interface bba_csr_if import bba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] base_address;

   modport source (output valid, base_address, input ready);
   modport sink   (input valid, base_address, output ready);
endinterface

### sv/buddy_block_allocator.sv
`timescale 1ns / 1ps
// Buddy block allocator over a pool of BLOCK_COUNT blocks of BLOCK_BYTES bytes
// (both powers of two). The tree lives in one single-port-read RAM of
// 2*BLOCK_COUNT words, each holding the node's free bit and the log size (+1)
// of the largest free block below it. After reset the block runs a clearing
// pass over all 2*BLOCK_COUNT words before it takes its first request; csr
// writes are taken throughout. One request is handled at a time. An allocate
// makes up to two RAM reads per level going down to the chosen node, then one
// read and one write per level going back up to refresh the largest-free
// sizes; a free makes one read per level walking up to the owning node, then
// one read and one write per level of refresh from there to the root; a usage
// report or a request rejected by the decoder goes straight to the result.
// Each result sits in an output register so the next request can be taken
// while it waits.
// depends on bba_pkg, bba_channels, bba_decode

module buddy_block_allocator import bba_pkg::*; #(
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
   parameter int BLOCK_COUNT = DEF_BLOCK_COUNT
) (
   input  logic  clock,
   input  logic  reset,
   bba_req_if.sink   req_port,
   bba_rsp_if.source rsp_port,
   bba_csr_if.sink   csr_port
);

   localparam int DEPTH = $clog2(BLOCK_COUNT);
   localparam int NW    = DEPTH + 1;
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(DEPTH + 2);
   localparam int MW    = CW + 1;
   localparam int SHIFT = $clog2(BLOCK_BYTES);
   localparam int NODES = 2 * BLOCK_COUNT;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECODE = 9'b000000100,
      S_DOWN   = 9'b000001000,
      S_LEFT   = 9'b000010000,
      S_UP     = 9'b000100000,
      S_FIX    = 9'b001000000,
      S_FIXW   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   function automatic logic [LW-1:0] floor_log2(input logic [NW-1:0] v);
      logic [LW-1:0] r;
      r = '0;
      for (int i = 0; i < NW; i++) begin
         if (v[i]) r = LW'(i);
      end
      return r;
   endfunction

   // tree ram
   logic [MW-1:0] tree_mem [NODES];
   logic [MW-1:0] rd_data_ff;
   logic          mem_we, mem_re;
   logic [NW-1:0] mem_wa, mem_ra;
   logic [MW-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) tree_mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= tree_mem[mem_ra];
   end

   logic          rd_bit;
   logic [CW-1:0] rd_code;
   assign rd_bit  = rd_data_ff[CW];
   assign rd_code = rd_data_ff[CW-1:0];

   // registers
   state_type         state_ff, state_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [NW-1:0]     leaf_ff, leaf_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [LW-1:0]     tgt_ff, tgt_in;
   logic [LW-1:0]     lg_ff, lg_in;
   logic [CW-1:0]     need_ff, need_in;
   logic [CW-1:0]     code_ff, code_in;
   logic [USED_W-1:0] used_ff, used_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_granted_ff, res_granted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;

   // request decoder
   decode_type    dec_ctl;
   logic [LW-1:0] dec_lg;
   logic [NW-1:0] dec_leaf;

   bba_decode #(
      .BLOCK_BYTES(BLOCK_BYTES),
      .BLOCK_COUNT(BLOCK_COUNT)
   ) u_decode (
      .kind           (kind_ff),
      .request_bytes  (size_ff),
      .release_address(addr_ff),
      .base_address   (base_ff),
      .ctl            (dec_ctl),
      .size_log       (dec_lg),
      .leaf           (dec_leaf)
   );

   // helpers for the walk
   logic [CW-1:0] clear_code;
   logic [LW-1:0] climb;
   logic [NW-1:0] node_shift;
   logic [NW-1:0] low_mask;
   logic [CW-1:0] full_code;
   logic [CW-1:0] parent_code;
   logic [NW-1:0] parent;

   assign clear_code  = CW'(DEPTH + 1) - CW'(floor_log2(clr_ff));
   assign climb       = LW'(DEPTH) - lvl_ff;
   assign node_shift  = cur_ff << lg_ff;
   assign low_mask    = ~({NW{1'b1}} << climb);
   assign full_code   = CW'(DEPTH + 1) - CW'(lvl_ff);
   assign parent      = cur_ff >> 1;
   assign parent_code = (code_ff == full_code && rd_code == full_code) ? full_code + CW'(1)
                      : (code_ff > rd_code) ? code_ff : rd_code;

   assign req_port.ready        = (state_ff == S_IDLE);
   assign csr_port.ready        = 1'b1;
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = rsp_status_ff;
   assign rsp_port.granted_address = rsp_granted_ff;
   assign rsp_port.used_blocks  = rsp_used_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      base_in        = base_ff;
      kind_in        = kind_ff;
      size_in        = size_ff;
      addr_in        = addr_ff;
      cur_in         = cur_ff;
      leaf_in        = leaf_ff;
      lvl_in         = lvl_ff;
      tgt_in         = tgt_ff;
      lg_in          = lg_ff;
      need_in        = need_ff;
      code_in        = code_ff;
      used_in        = used_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = '0;
      mem_re         = 1'b0;
      mem_ra         = '0;

      // csr write
      if (csr_port.valid) base_in = csr_port.base_address;

      // response taken
      if (rsp_valid_ff && rsp_port.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_ff == '0) ? '0 : {1'b1, clear_code};
            clr_in = clr_ff + NW'(1);
            if (clr_ff == NW'(NODES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_port.valid) begin
               kind_in  = req_port.kind;
               size_in  = req_port.request_bytes;
               addr_in  = req_port.release_address;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_granted_in = '0;
            res_status_in  = dec_ctl.status;
            lg_in          = dec_lg;
            leaf_in        = dec_leaf;
            if (dec_ctl.done) begin
               state_in = S_DONE;
            end else if (dec_ctl.alloc) begin
               need_in  = CW'(dec_lg) + CW'(1);
               tgt_in   = LW'(DEPTH) - dec_lg;
               cur_in   = NW'(1);
               lvl_in   = '0;
               mem_re   = 1'b1;
               mem_ra   = NW'(1);
               state_in = S_DOWN;
            end else begin
               cur_in   = dec_leaf;
               lvl_in   = LW'(DEPTH);
               mem_re   = 1'b1;
               mem_ra   = dec_leaf;
               state_in = S_UP;
            end
         end
         // read data holds the current node on the way down
         S_DOWN: begin
            if (cur_ff == NW'(1) && rd_code < need_ff) begin
               res_status_in = ST_NO_MEMORY;
               state_in      = S_DONE;
            end else if (lvl_ff == tgt_ff) begin
               mem_we         = 1'b1;
               mem_wa         = cur_ff;
               mem_wd         = '0;
               code_in        = '0;
               used_in        = used_ff + (USED_W'(1) << lg_ff);
               res_granted_in = base_ff + (ADDR_W'(node_shift[DEPTH-1:0]) << SHIFT);
               state_in       = (cur_ff == NW'(1)) ? S_DONE : S_FIX;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = cur_ff << 1;
               state_in = S_LEFT;
            end
         end
         // read data holds the left child
         S_LEFT: begin
            lvl_in   = lvl_ff + LW'(1);
            state_in = S_DOWN;
            if (rd_code >= need_ff) begin
               cur_in = cur_ff << 1;
            end else begin
               cur_in = (cur_ff << 1) | NW'(1);
               mem_re = 1'b1;
               mem_ra = (cur_ff << 1) | NW'(1);
            end
         end
         // free: climb to the owning node
         S_UP: begin
            if (!rd_bit) begin
               if ((leaf_ff & low_mask) != '0) begin
                  res_status_in = ST_INVALID_PTR;
                  state_in      = S_DONE;
               end else begin
                  mem_we   = 1'b1;
                  mem_wa   = cur_ff;
                  mem_wd   = {1'b1, CW'(climb) + CW'(1)};
                  code_in  = CW'(climb) + CW'(1);
                  used_in  = used_ff - (USED_W'(1) << climb);
                  state_in = (cur_ff == NW'(1)) ? S_DONE : S_FIX;
               end
            end else if (cur_ff == NW'(1)) begin
               res_status_in = ST_INVALID_PTR;
               state_in      = S_DONE;
            end else begin
               cur_in   = parent;
               lvl_in   = lvl_ff - LW'(1);
               mem_re   = 1'b1;
               mem_ra   = parent;
               state_in = S_UP;
            end
         end
         // refresh largest-free sizes toward the root
         S_FIX: begin
            mem_re   = 1'b1;
            mem_ra   = cur_ff ^ NW'(1);
            state_in = S_FIXW;
         end
         S_FIXW: begin
            mem_we   = 1'b1;
            mem_wa   = parent;
            mem_wd   = {1'b1, parent_code};
            cur_in   = parent;
            lvl_in   = lvl_ff - LW'(1);
            code_in  = parent_code;
            state_in = (parent == NW'(1)) ? S_DONE : S_FIX;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_used_in    = used_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      size_ff        <= size_in;
      addr_ff        <= addr_in;
      cur_ff         <= cur_in;
      leaf_ff        <= leaf_in;
      lvl_ff         <= lvl_in;
      tgt_ff         <= tgt_in;
      lg_ff          <= lg_in;
      need_ff        <= need_in;
      code_ff        <= code_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
   end

endmodule

### sv/bba_decode.sv
`timescale 1ns / 1ps
// request decoder: size rounding, address range and alignment checks
// depends on bba_pkg

module bba_decode import bba_pkg::*; #(
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
   parameter int BLOCK_COUNT = DEF_BLOCK_COUNT
) (
   input  logic [KIND_W-1:0]                   kind,
   input  logic [SIZE_W-1:0]                   request_bytes,
   input  logic [ADDR_W-1:0]                   release_address,
   input  logic [ADDR_W-1:0]                   base_address,
   output decode_type                          ctl,
   output logic [$clog2($clog2(BLOCK_COUNT)+1)-1:0] size_log,
   output logic [$clog2(BLOCK_COUNT):0]        leaf
);

   localparam int    DEPTH      = $clog2(BLOCK_COUNT);
   localparam int    LW         = $clog2(DEPTH + 1);
   localparam int    SHIFT      = $clog2(BLOCK_BYTES);
   localparam longint POOL_BYTES = longint'(BLOCK_COUNT) * longint'(BLOCK_BYTES);

   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] block_idx;
   logic              fits;

   assign offset    = release_address - base_address;
   assign block_idx = offset >> SHIFT;

   // smallest power-of-two block count that covers the byte size
   always_comb begin
      fits     = 1'b0;
      size_log = '0;
      for (int k = DEPTH; k >= 0; k--) begin
         if (longint'(request_bytes) <= (longint'(BLOCK_BYTES) << k)) begin
            fits     = 1'b1;
            size_log = LW'(k);
         end
      end
   end

   // leaf of the released block
   assign leaf = {1'b1, block_idx[DEPTH-1:0]};

   // classify the transaction
   always_comb begin
      ctl = '{done: 1'b1, status: ST_OK, alloc: 1'b0};
      case (kind)
         KIND_ALLOC: begin
            if (request_bytes == '0) begin
               ctl.status = ST_INVALID_SIZE;
            end else if (longint'(request_bytes) > POOL_BYTES || !fits) begin
               ctl.status = ST_NO_MEMORY;
            end else begin
               ctl.done  = 1'b0;
               ctl.alloc = 1'b1;
            end
         end
         KIND_FREE: begin
            if (release_address == '0) begin
               ctl.status = ST_OK;
            end else if (release_address < base_address
                         || longint'(offset) >= POOL_BYTES
                         || (offset & ADDR_W'(BLOCK_BYTES - 1)) != '0) begin
               ctl.status = ST_INVALID_PTR;
            end else begin
               ctl.done = 1'b0;
            end
         end
         default: begin
            ctl.status = ST_OK;
         end
      endcase
   end

endmodule

### sv/bba_checker.sv
`timescale 1ns / 1ps
// port-level checks of the buddy block allocator, bound to the top level
// depends on bba_pkg and buddy_block_allocator

module bba_checker import bba_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_granted,
   input logic [USED_W-1:0]   rsp_used
);

   // only a successful allocate carries an address
   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted == '0)
      else $error("granted address set on a failed transaction");

   // one transaction in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted) && $stable(rsp_used))
      else $error("stalled response changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_status (rsp_port.status),
   .rsp_granted(rsp_port.granted_address),
   .rsp_used   (rsp_port.used_blocks)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the buddy block allocator: directed table, then random
// allocate/free/usage traffic checked against a behavioral model of the bit tree
// depends on bba_pkg, bba_channels, buddy_block_allocator

module tb_top;
   import bba_pkg::*;

   localparam int BLK_BYTES  = DEF_BLOCK_BYTES;
   localparam int BLK_COUNT  = DEF_BLOCK_COUNT;
   localparam int POOL_SPAN  = BLK_BYTES * BLK_COUNT;
   localparam int TREE_DEPTH = $clog2(BLK_COUNT);
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bba_req_if req_if ();
   bba_rsp_if rsp_if ();
   bba_csr_if csr_if ();

   buddy_block_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if.sink),
      .rsp_port (rsp_if.source),
      .csr_port (csr_if.sink)
   );

   always #4 clock = ~clock;

   // one expected response
   typedef struct {
      status_type  status;
      logic [31:0] granted;
      logic [8:0]  used;
   } alloc_result_type;

   // one row of the directed table; check_row marks rows with a typed-in answer
   typedef struct {
      kind_type    kind;
      logic [14:0] bytes;
      logic [31:0] addr;
      bit          check_row;
      status_type  status;
      logic [31:0] granted;
      logic [8:0]  used;
   } stim_row_type;

   // model state
   bit          tree_bits [2*BLK_COUNT];
   logic [8:0]  blocks_in_use;
   logic [31:0] pool_base;

   alloc_result_type pending_results[$];
   logic [31:0]   live_allocs[$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            rsp_stall_enable = 1'b1;

   task automatic report(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void tree_clear();
      foreach (tree_bits[i]) tree_bits[i] = 1'b1;
      tree_bits[0] = 1'b0;
      blocks_in_use = '0;
   endfunction

   function automatic bit subtree_free(input int node, input int lvl);
      int p;
      int first;
      int cnt;
      p = node >> 1;
      while (p >= 1) begin
         if (!tree_bits[p]) return 1'b0;
         p = p >> 1;
      end
      for (int l = lvl; l <= TREE_DEPTH; l++) begin
         first = node << (l - lvl);
         cnt = 1 << (l - lvl);
         for (int i = 0; i < cnt; i++)
            if (!tree_bits[first + i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // apply one request to the model tree and return its response
   function automatic alloc_result_type predict_alloc(input logic [1:0] kind,
         input logic [14:0] bytes, input logic [31:0] addr);
      alloc_result_type r;
      int blocks;
      int lg;
      int lvl;
      int node;
      int leaf;
      longint off;
      bit found;
      r.status = ST_OK;
      r.granted = '0;
      if (kind == KIND_ALLOC) begin
         if (bytes == 0) r.status = ST_INVALID_SIZE;
         else if (bytes > POOL_SPAN) r.status = ST_NO_MEMORY;
         else begin
            blocks = (bytes + BLK_BYTES - 1) / BLK_BYTES;
            lg = 0;
            while ((1 << lg) < blocks) lg++;
            lvl = TREE_DEPTH - lg;
            found = 1'b0;
            for (int i = 0; i < (1 << lvl) && !found; i++) begin
               node = (1 << lvl) + i;
               if (subtree_free(node, lvl)) begin
                  leaf = node << lg;
                  tree_bits[node] = 1'b0;
                  blocks_in_use = blocks_in_use + 9'(1 << lg);
                  r.granted = pool_base + 32'((leaf - BLK_COUNT) * BLK_BYTES);
                  found = 1'b1;
               end
            end
            if (!found) r.status = ST_NO_MEMORY;
         end
      end else if (kind == KIND_FREE && addr != 0) begin
         off = longint'(addr) - longint'(pool_base);
         if (addr < pool_base || off >= POOL_SPAN || off % BLK_BYTES != 0)
            r.status = ST_INVALID_PTR;
         else begin
            leaf = int'(off / BLK_BYTES) + BLK_COUNT;
            node = leaf;
            while (node != 0 && tree_bits[node]) node = node >> 1;
            lvl = (node == 0) ? 0 : $clog2(node + 1) - 1;
            if (node == 0 || (node << (TREE_DEPTH - lvl)) != leaf)
               r.status = ST_INVALID_PTR;
            else begin
               tree_bits[node] = 1'b1;
               blocks_in_use = blocks_in_use - 9'(1 << (TREE_DEPTH - lvl));
            end
         end
      end
      r.used = blocks_in_use;
      return r;
   endfunction

   // issue one request transaction, with random idle bursts when enabled;
   // valid stays high after acceptance until the next idle or drain
   task automatic send_request(input logic [1:0] kind, input logic [14:0] bytes,
         input logic [31:0] addr, input bit idle_ok);
      alloc_result_type r;
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.kind            <= kind;
      req_if.request_bytes   <= bytes;
      req_if.release_address <= addr;
      do @(posedge clock); while (!req_if.ready);
      r = predict_alloc(kind, bytes, addr);
      pending_results.push_back(r);
      if (r.status == ST_OK && kind == KIND_ALLOC) live_allocs.push_back(r.granted);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_base(input logic [31:0] value);
      csr_if.valid        <= 1'b1;
      csr_if.base_address <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      pool_base = value;
   endtask

   // release everything the model holds so a new base starts from an empty pool
   task automatic release_all();
      while (live_allocs.size() != 0)
         send_request(KIND_FREE, '0, live_allocs.pop_front(), 1'b1);
   endtask

   // response check
   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0)
            report("response with no request outstanding");
         else begin
            e = pending_results.pop_front();
            if (rsp_if.status !== e.status)
               report($sformatf("status %0d, expected %0d", rsp_if.status, e.status));
            if (rsp_if.granted_address !== e.granted)
               report($sformatf("granted_address %h, expected %h",
                  rsp_if.granted_address, e.granted));
            if (rsp_if.used_blocks !== e.used)
               report($sformatf("used_blocks %0d, expected %0d",
                  rsp_if.used_blocks, e.used));
         end
      end
   end

   // response back-pressure in random bursts
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_enable && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // directed table: extremes, every kind and each special case; pool base is 0x1000
   stim_row_type dir_rows[] = '{
      '{KIND_USAGE, 15'd0,     32'd0,          1'b1, ST_OK,           32'd0, 9'd0},
      '{kind_type'(2'd3), 15'h7fff, 32'hffffffff, 1'b1, ST_OK,       32'd0, 9'd0},
      '{KIND_ALLOC, 15'd0,     32'd0,          1'b1, ST_INVALID_SIZE, 32'd0, 9'd0},
      '{KIND_ALLOC, 15'd16385, 32'd0,          1'b1, ST_NO_MEMORY,    32'd0, 9'd0},
      '{KIND_ALLOC, 15'h7fff,  32'd0,          1'b1, ST_NO_MEMORY,    32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'd0,          1'b1, ST_OK,           32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'h5000,       1'b1, ST_INVALID_PTR,  32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'h1041,       1'b1, ST_INVALID_PTR,  32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'd64,         1'b1, ST_INVALID_PTR,  32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'h1040,       1'b1, ST_INVALID_PTR,  32'd0, 9'd0},
      '{KIND_ALLOC, 15'd16384, 32'd0,          1'b1, ST_OK,           32'h1000, 9'd256},
      '{KIND_ALLOC, 15'd1,     32'd0,          1'b1, ST_NO_MEMORY,    32'd0, 9'd256},
      '{KIND_FREE,  15'd0,     32'h1040,       1'b1, ST_INVALID_PTR,  32'd0, 9'd256},
      '{KIND_FREE,  15'd0,     32'hffffffff,   1'b1, ST_INVALID_PTR,  32'd0, 9'd256},
      '{KIND_FREE,  15'd0,     32'h1000,       1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'd0,          1'b1, ST_OK,           32'd0, 9'd0},
      '{KIND_ALLOC, 15'd1,     32'd0,          1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_ALLOC, 15'd65,    32'd0,          1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_ALLOC, 15'd64,    32'd0,          1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_ALLOC, 15'd8192,  32'd0,          1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'h1080,       1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_FREE,  15'd0,     32'h10c0,       1'b0, ST_OK,           32'd0, 9'd0},
      '{KIND_USAGE, 15'd0,     32'd0,          1'b0, ST_OK,           32'd0, 9'd0}
   };

   // random request mix, mostly allocate/free of real allocations
   task automatic random_phase(input int count, input bit idle_ok);
      int pick;
      int idx;
      logic [31:0] a;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 3) == 0) send_request(KIND_ALLOC, 15'($urandom), '0, idle_ok);
            else if ($urandom_range(0, 9) == 0)
               send_request(KIND_ALLOC, 15'($urandom_range(1, POOL_SPAN)), '0, idle_ok);
            else send_request(KIND_ALLOC, 15'($urandom_range(1, 1024)), '0, idle_ok);
         end else if (pick < 85 && live_allocs.size() != 0) begin
            idx = $urandom_range(0, live_allocs.size() - 1);
            a = live_allocs[idx];
            live_allocs.delete(idx);
            send_request(KIND_FREE, 15'($urandom), a, idle_ok);
         end else if (pick < 95) begin
            // bad pointer: random, near the pool, or a double free
            case ($urandom_range(0, 2))
               0: a = $urandom;
               1: a = pool_base + 32'($urandom_range(0, POOL_SPAN + 256));
               default: a = pool_base + 32'($urandom_range(0, BLK_COUNT - 1) * BLK_BYTES);
            endcase
            send_request(KIND_FREE, 15'($urandom), a, idle_ok);
            // a lucky hit may have freed a live allocation; drop it from the list
            foreach (live_allocs[i])
               if (live_allocs[i] == a && pending_results[$].status == ST_OK) begin
                  live_allocs.delete(i);
                  break;
               end
         end else
            send_request(kind_type'($urandom_range(2, 3)), 15'($urandom), $urandom, idle_ok);
      end
   endtask

   initial begin
      logic [31:0] bases[4];
      alloc_result_type r;
      req_if.valid = 1'b0;
      req_if.kind = KIND_USAGE;
      req_if.request_bytes = '0;
      req_if.release_address = '0;
      csr_if.valid = 1'b0;
      csr_if.base_address = '0;
      pool_base = '0;
      tree_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // nonzero base so the block at the pool start can be freed
      write_base(32'h0000_1000);

      // directed table walk
      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].kind, dir_rows[i].bytes, dir_rows[i].addr, 1'b1);
         if (dir_rows[i].check_row) begin
            r = pending_results[$];
            if (r.status != dir_rows[i].status || r.granted != dir_rows[i].granted ||
                r.used != dir_rows[i].used)
               report($sformatf("directed row %0d disagrees with table", i));
            pending_results[$] = '{dir_rows[i].status, dir_rows[i].granted,
               dir_rows[i].used};
         end
      end
      // the full-pool allocation was freed by its row; realign the live list
      live_allocs.delete();
      foreach (tree_bits[n])
         if (n >= 1 && !tree_bits[n])
            live_allocs.push_back(pool_base
               + 32'(((n << (TREE_DEPTH - ($clog2(n + 1) - 1))) - BLK_COUNT) * BLK_BYTES));

      // hold off until every result is in
      wait_drained();

      // random phases under several pool bases, extremes included
      bases = '{32'hffffffff - POOL_SPAN + 1 + 32'($urandom_range(0, 0)), 32'h8000_1000,
                32'hffffff00, 32'd0};
      for (int ph = 0; ph < 4; ph++) begin
         release_all();
         wait_drained();
         write_base(bases[ph]);
         random_phase(ph == 3 ? 150 : 280, 1'b1);
      end
      // last part: no idling on either side
      rsp_stall_enable = 1'b0;
      random_phase(100, 1'b0);

      wait_drained();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
